### src/atn2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn2r_pkg
// Shared widths, constants and types of the rational arctangent pipeline.
// ----------------------------------------------------------------------------
package atn2r_pkg;

   // Sample and angle widths.
   localparam int DATA_W = 16;
   localparam int ANGLE_W = 16;

   // Magnitude of a 16-bit sample needs 17 bits (the most negative input).
   localparam int MAG_W = DATA_W + 1;

   // First divider: r = floor(a * 2^15 / b), one quotient bit per cell.
   localparam int QUO1_W = 16;
   localparam int REM1_W = MAG_W;
   localparam int TAIL1_W = 1;

   // Second divider: f = floor((r * 2^14 + d) / (2 d)), f below 2^14.
   localparam int QUO2_W = 14;
   localparam int REM2_W = 18;
   localparam int TAIL2_W = QUO2_W - 1;
   localparam int NUM2_W = QUO1_W + QUO2_W;

   // r^2 and 0.28 r^2 in Q1.15.
   localparam int SQR_W = 16;
   localparam int K_W = 14;
   localparam int D_W = 16;

   // The factor 0.28 as 18350 / 2^16.
   localparam logic [14:0] K_028_Q16 = 15'd18350;
   localparam logic [D_W-1:0] ONE_Q15 = 16'd32768;

   // Angle constants in Q3.13, one bit wider for the sum.
   localparam int SUM_W = ANGLE_W + 1;
   localparam logic signed [SUM_W-1:0] ANG_PI = 17'sd25736;
   localparam logic signed [SUM_W-1:0] ANG_HALF_PI = 17'sd12868;

   // Case flags that ride along with each item.
   typedef struct packed {
      logic x_zero;
      logic y_zero;
      logic y_neg;
      logic x_neg;
      logic recip;
   } atn2r_flags_type;

   localparam int FLAGS_W = $bits(atn2r_flags_type);

endpackage

### src/atn2r_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn2r_div_cell
// One restoring division step: decides one quotient bit and hands the
// partial remainder, divisor, quotient and side data to the next cell.
// ----------------------------------------------------------------------------
module atn2r_div_cell
   import atn2r_pkg::*;
#(
   parameter int REM_W = REM1_W,
   parameter int QUO_W = QUO1_W,
   parameter int TAIL_W = TAIL1_W,
   parameter int SIDE_W = FLAGS_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [REM_W-1:0]  in_rem,
   input  logic [REM_W-1:0]  in_den,
   input  logic [QUO_W-1:0]  in_quo,
   input  logic [TAIL_W-1:0] in_tail,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [REM_W-1:0]  out_rem,
   output logic [REM_W-1:0]  out_den,
   output logic [QUO_W-1:0]  out_quo,
   output logic [TAIL_W-1:0] out_tail,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  den_ff;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [TAIL_W-1:0] tail_ff, tail_in;
   logic [SIDE_W-1:0] side_ff;
   logic              ge;
   logic [REM_W-1:0]  diff;

   // Trial subtraction; the remainder then shifts up and takes the next dividend bit.
   always_comb begin
      ge = (in_rem >= in_den);
      diff = ge ? (in_rem - in_den) : in_rem;
      rem_in = {diff[REM_W-2:0], in_tail[TAIL_W-1]};
      quo_in = {in_quo[QUO_W-2:0], ge};
      tail_in = in_tail << 1;
   end

   // Valid bit of this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   // Data registers of this cell.
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
         tail_ff <= tail_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_quo = quo_ff;
   assign out_tail = tail_ff;
   assign out_side = side_ff;

endmodule

### src/atn2r_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atn2r_poly
// Two multiply stages that form r^2 and then 0.28 r^2 in Q1.15.
// ----------------------------------------------------------------------------
module atn2r_poly
   import atn2r_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [QUO1_W-1:0] in_r,
   input  atn2r_flags_type in_flags,
   output logic            out_valid,
   output logic [QUO1_W-1:0] out_r,
   output logic [K_W-1:0]  out_k,
   output atn2r_flags_type out_flags
);

   logic                   s1_valid_ff, s2_valid_ff;
   logic [QUO1_W-1:0]      s1_r_ff, s2_r_ff;
   logic [SQR_W-1:0]       s1_t_ff, s1_t_in;
   logic [K_W-1:0]         s2_k_ff, s2_k_in;
   atn2r_flags_type        s1_flags_ff, s2_flags_ff;
   logic [2*QUO1_W-1:0]    sq_prod;
   logic [31:0]            k_prod;

   // r^2 scaled back to Q1.15, then the 0.28 factor.
   always_comb begin
      sq_prod = in_r * in_r;
      s1_t_in = sq_prod[30:15];
      k_prod = 32'(s1_t_ff) * 32'(K_028_Q16);
      s2_k_in = k_prod[29:16];
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage data.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_r_ff <= in_r;
         s1_t_ff <= s1_t_in;
         s1_flags_ff <= in_flags;
         s2_r_ff <= s1_r_ff;
         s2_k_ff <= s2_k_in;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_r = s2_r_ff;
   assign out_k = s2_k_ff;
   assign out_flags = s2_flags_ff;

endmodule

### src/atan2_rational_approx.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_rational_approx
// Four-quadrant arctangent of a signed 16-bit pair by r / (1 + 0.28 r^2).
// ----------------------------------------------------------------------------
// The block takes one (y, x) item per clock and returns its angle in signed
// Q3.13 radians: 16 division cells form the ratio of the smaller to the
// larger magnitude, two multiply stages form 0.28 r^2, 14 more division
// cells form r / (1 + 0.28 r^2), and one output register applies the
// quadrant correction. The whole pipeline moves together and holds only while
// a finished item sits in the output register with rsp_stall high, so the
// sustained rate is one item per cycle. There is no configuration and no
// state beyond the items in flight.
// ----------------------------------------------------------------------------
module atan2_rational_approx
   import atn2r_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DATA_W-1:0]  req_y_value,
   input  logic signed [DATA_W-1:0]  req_x_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ANGLE_W-1:0] rsp_angle
);

   localparam int N1 = QUO1_W;
   localparam int N2 = QUO2_W;

   logic adv;

   // First divider chain.
   logic                d1_valid [0:N1];
   logic [REM1_W-1:0]   d1_rem   [0:N1];
   logic [REM1_W-1:0]   d1_den   [0:N1];
   logic [QUO1_W-1:0]   d1_quo   [0:N1];
   logic [TAIL1_W-1:0]  d1_tail  [0:N1];
   logic [FLAGS_W-1:0]  d1_side  [0:N1];

   // Second divider chain.
   logic                d2_valid [0:N2];
   logic [REM2_W-1:0]   d2_rem   [0:N2];
   logic [REM2_W-1:0]   d2_den   [0:N2];
   logic [QUO2_W-1:0]   d2_quo   [0:N2];
   logic [TAIL2_W-1:0]  d2_tail  [0:N2];
   logic [FLAGS_W-1:0]  d2_side  [0:N2];

   logic signed [MAG_W-1:0] y_ext, x_ext;
   logic [MAG_W-1:0]        ay, ax;
   atn2r_flags_type         in_flags;
   atn2r_flags_type         r_flags;

   logic                    p_valid;
   logic [QUO1_W-1:0]       p_r;
   logic [K_W-1:0]          p_k;
   atn2r_flags_type         p_flags;
   logic [D_W-1:0]          dsum;
   logic [NUM2_W-1:0]       num2;

   atn2r_flags_type         o_flags;
   logic signed [SUM_W-1:0] f_ext, f_sgn, ang;
   logic                    neg_f, opposite;
   logic                    rsp_valid_ff;
   logic signed [ANGLE_W-1:0] angle_ff, angle_in;

   // The pipeline advances unless a finished item is held at the output.
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Magnitudes, ordering and case flags of the incoming item.
   always_comb begin
      y_ext = MAG_W'(req_y_value);
      x_ext = MAG_W'(req_x_value);
      ay = y_ext[MAG_W-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
      ax = x_ext[MAG_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
      in_flags.x_zero = (req_x_value == '0);
      in_flags.y_zero = (req_y_value == '0);
      in_flags.y_neg = req_y_value[DATA_W-1];
      in_flags.x_neg = req_x_value[DATA_W-1];
      in_flags.recip = (ay >= ax);
   end

   assign d1_valid[0] = req_valid;
   assign d1_rem[0] = in_flags.recip ? ax : ay;
   assign d1_den[0] = in_flags.recip ? ay : ax;
   assign d1_quo[0] = '0;
   assign d1_tail[0] = '0;
   assign d1_side[0] = in_flags;

   // Ratio r = smaller / larger magnitude in Q1.15, one bit per cell.
   for (genvar i = 0; i < N1; i++) begin : g_div1
      atn2r_div_cell #(
         .REM_W  (REM1_W),
         .QUO_W  (QUO1_W),
         .TAIL_W (TAIL1_W),
         .SIDE_W (FLAGS_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (d1_valid[i]),
         .in_rem    (d1_rem[i]),
         .in_den    (d1_den[i]),
         .in_quo    (d1_quo[i]),
         .in_tail   (d1_tail[i]),
         .in_side   (d1_side[i]),
         .out_valid (d1_valid[i+1]),
         .out_rem   (d1_rem[i+1]),
         .out_den   (d1_den[i+1]),
         .out_quo   (d1_quo[i+1]),
         .out_tail  (d1_tail[i+1]),
         .out_side  (d1_side[i+1])
      );
   end

   assign r_flags = atn2r_flags_type'(d1_side[N1]);

   // 0.28 r^2.
   atn2r_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d1_valid[N1]),
      .in_r      (d1_quo[N1]),
      .in_flags  (r_flags),
      .out_valid (p_valid),
      .out_r     (p_r),
      .out_k     (p_k),
      .out_flags (p_flags)
   );

   // Dividend r * 2^14 + d and divisor 2 d for the rounded quotient.
   always_comb begin
      dsum = ONE_Q15 + D_W'(p_k);
      num2 = {p_r, {QUO2_W{1'b0}}} + NUM2_W'(dsum);
   end

   assign d2_valid[0] = p_valid;
   assign d2_rem[0] = REM2_W'(num2[NUM2_W-1:TAIL2_W]);
   assign d2_den[0] = REM2_W'({dsum, 1'b0});
   assign d2_quo[0] = '0;
   assign d2_tail[0] = num2[TAIL2_W-1:0];
   assign d2_side[0] = p_flags;

   // f = r / (1 + 0.28 r^2) in Q3.13, one bit per cell.
   for (genvar j = 0; j < N2; j++) begin : g_div2
      atn2r_div_cell #(
         .REM_W  (REM2_W),
         .QUO_W  (QUO2_W),
         .TAIL_W (TAIL2_W),
         .SIDE_W (FLAGS_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (d2_valid[j]),
         .in_rem    (d2_rem[j]),
         .in_den    (d2_den[j]),
         .in_quo    (d2_quo[j]),
         .in_tail   (d2_tail[j]),
         .in_side   (d2_side[j]),
         .out_valid (d2_valid[j+1]),
         .out_rem   (d2_rem[j+1]),
         .out_den   (d2_den[j+1]),
         .out_quo   (d2_quo[j+1]),
         .out_tail  (d2_tail[j+1]),
         .out_side  (d2_side[j+1])
      );
   end

   // Sign and quadrant correction.
   always_comb begin
      o_flags = atn2r_flags_type'(d2_side[N2]);
      opposite = o_flags.y_neg != o_flags.x_neg;
      neg_f = o_flags.recip ? opposite : (opposite && !o_flags.y_zero);
      f_ext = SUM_W'(d2_quo[N2]);
      f_sgn = neg_f ? -f_ext : f_ext;
      if (o_flags.x_zero) begin
         if (o_flags.y_neg) begin
            ang = -ANG_HALF_PI;
         end else if (o_flags.y_zero) begin
            ang = '0;
         end else begin
            ang = ANG_HALF_PI;
         end
      end else if (!o_flags.recip) begin
         if (!o_flags.x_neg) begin
            ang = f_sgn;
         end else if (o_flags.y_neg) begin
            ang = f_sgn - ANG_PI;
         end else begin
            ang = f_sgn + ANG_PI;
         end
      end else begin
         ang = ANG_HALF_PI - f_sgn - (o_flags.y_neg ? ANG_PI : SUM_W'(0));
      end
      angle_in = ang[ANGLE_W-1:0];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d2_valid[N2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = angle_ff;

   // The ratio never exceeds one when x is nonzero; the origin divides zero by zero.
   a_ratio_max : assert property (@(posedge clock) disable iff (reset)
      (d1_valid[N1] && !r_flags.x_zero) |-> (d1_quo[N1] <= QUO1_W'(32768)))
      else $error("Ratio quotient above one.");

   // The rational term never exceeds one in Q3.13 when x is nonzero.
   a_frac_max : assert property (@(posedge clock) disable iff (reset)
      (d2_valid[N2] && !o_flags.x_zero) |-> (d2_quo[N2] <= QUO2_W'(8192)))
      else $error("Rational term above one.");

   // Every delivered angle lies within plus or minus pi.
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (angle_ff <= 16'sd25736 && angle_ff >= -16'sd25736))
      else $error("Angle outside plus or minus pi.");

   // A held output freezes the divider chain.
   a_freeze : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(d2_quo[N2]))
      else $error("Pipeline moved while the output was held.");

   // The output is empty when reset is released.
   a_reset_empty : assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_valid_ff)
      else $error("Output valid right after reset.");

endmodule
